### hdl/hds_pkg.sv
// Shared types, constants and helpers for the heat diffusion stencil block.
// Used by hds_line_store and heat_diffusion_stencil_2d; no dependencies.
package hds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int IDX_W      = 10;
    localparam int TEMP_W     = 16;
    localparam int COEF_W     = 15;
    localparam int SUM_W      = TEMP_W + 2;
    localparam int SELF_W     = 17;
    localparam int PROD_W     = 33;
    localparam int ACC_W      = 34;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [TEMP_W-1:0] ONE_Q15    = 16'd32768;
    localparam logic [COEF_W-1:0] LAMBDA_CAP = 15'd16384;
    localparam logic [SELF_W-1:0] UNITY_Q16  = 17'd65536;
    localparam logic [ACC_W-1:0]  HALF_Q16   = 34'd32768;

    localparam logic [DIM_W-1:0]  DIM_MIN    = 11'd3;
    localparam logic [DIM_W-1:0]  WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_DIFF_COEFF  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              rd_en;
        logic [COL_W-1:0]  col;
        logic [TEMP_W-1:0] temp;
        logic              wb_en;
        logic [COL_W-1:0]  wb_col;
    } t_ls_req;

    typedef struct packed {
        logic [TEMP_W-1:0] centre;
        logic [TEMP_W-1:0] east;
        logic [TEMP_W-1:0] north;
        logic [TEMP_W-1:0] west;
    } t_ls_rd;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              emit_a;
        logic              emit_b;
        logic              bnd;
        logic              last;
    } t_meta;

    function automatic logic [TEMP_W-1:0] sat_q15(input logic [SUM_W-1:0] v);
        sat_q15 = (v > SUM_W'(ONE_Q15)) ? ONE_Q15 : v[TEMP_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        if (v < DIM_MIN) begin
            clamp_dim = DIM_MIN;
        end else if (v > maxv) begin
            clamp_dim = maxv;
        end else begin
            clamp_dim = v;
        end
    endfunction

endpackage

### hdl/heat_diffusion_stencil_2d.sv
// Streaming five-point heat-equation stencil, one explicit time step per pass.
// Depends on hds_pkg and hds_line_store.
//
// Input channel: i_valid / o_stall with i_temp_in, one grid cell per transfer in
// raster order. Output channel: o_valid / i_stall with o_temp_out, o_out_row,
// o_out_col and o_last_of_grid. Configuration: i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; o_cfg_ready is always high. Write the grid size
// and coefficient only while the block is idle.
// The cell arriving at (i,j) produces the result for (i-1,j); during the last
// row it also produces (i,j), presented once the (i-1,j) result is taken.
// Throughput is one cell per cycle while the output does not stall, limited to
// one result per cycle by the output register, so a last-row cell holds the
// pipeline until both its results go. Latency comes from the line store read,
// the multiplier stage and the output register, fed by rounding and saturation.
// Reset clears the position counters and the pipeline and loads the default
// 1024 x 1024 grid with lambda = 4096; the line stores need no clearing.
// A stall on the output holds the result and fills the pipeline behind it;
// o_stall rises only when every stage holds an item.
module heat_diffusion_stencil_2d import hds_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [TEMP_W-1:0]     i_temp_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TEMP_W-1:0]     o_temp_out,
    output logic [IDX_W-1:0]      o_out_row,
    output logic [IDX_W-1:0]      o_out_col,
    output logic                  o_last_of_grid,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [COEF_W-1:0] r_coeff;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic              r_v1;
    logic              r_v2;
    t_meta             r_m1;
    t_meta             r_m2;
    logic [TEMP_W-1:0] r_c2;
    logic [PROD_W-1:0] r_p_self;
    logic [PROD_W-1:0] r_p_lam;

    logic              r_pend_a;
    logic              r_pend_b;
    logic [TEMP_W-1:0] r_val_a;
    logic [TEMP_W-1:0] r_val_b;
    logic [ROW_W-1:0]  r_row3;
    logic [COL_W-1:0]  r_col3;
    logic              r_last3;

    logic [DIM_W-1:0]  c_w;
    logic [DIM_W-1:0]  c_h;
    logic [COEF_W-1:0] c_lam;
    logic [SELF_W-1:0] c_self;
    logic              c_wrap;
    logic [DIM_W-1:0]  c_i0;
    logic [ROW_W-1:0]  c_i;
    logic [COL_W-1:0]  c_j;
    logic [DIM_W-1:0]  c_jn;
    logic [DIM_W-1:0]  c_in;
    logic              c_last_col;

    logic              c_accept;
    logic              c_xfer;
    logic              c_en1;
    logic              c_en2;
    logic              c_en3;
    logic [SUM_W-1:0]  c_sum;
    logic [ACC_W-1:0]  c_acc;
    logic [SUM_W-1:0]  c_q;

    t_ls_req           c_req;
    t_ls_rd            c_rd;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_MAX;
            r_height <= HEIGHT_MAX;
            r_coeff  <= 15'd4096;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_DIFF_COEFF:  r_coeff  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign c_w    = clamp_dim(r_width, WIDTH_MAX);
    assign c_h    = clamp_dim(r_height, HEIGHT_MAX);
    assign c_lam  = (r_coeff > LAMBDA_CAP) ? LAMBDA_CAP : r_coeff;
    assign c_self = UNITY_Q16 - {c_lam, 2'b00};

    // pipeline flow control
    assign o_valid  = r_pend_a || r_pend_b;
    assign c_xfer   = o_valid && !i_stall;
    assign c_en3    = !o_valid || (c_xfer && !(r_pend_a && r_pend_b));
    assign c_en2    = !r_v2 || c_en3;
    assign c_en1    = !r_v1 || c_en2;
    assign o_stall  = !c_en1;
    assign c_accept = i_valid && c_en1;

    // raster position of the arriving cell
    always_comb begin
        c_wrap     = DIM_W'(r_col) >= c_w;
        c_i0       = c_wrap ? DIM_W'(r_row) + DIM_W'(1) : DIM_W'(r_row);
        c_i        = (c_i0 >= c_h) ? '0 : c_i0[ROW_W-1:0];
        c_j        = c_wrap ? '0 : r_col;
        c_last_col = DIM_W'(c_j) == c_w - DIM_W'(1);
        c_jn       = DIM_W'(c_j) + DIM_W'(1);
        c_in       = DIM_W'(c_i) + DIM_W'(1);
        if (c_jn >= c_w) begin
            n_col = '0;
            n_row = (c_in >= c_h) ? '0 : c_in[ROW_W-1:0];
        end else begin
            n_col = c_jn[COL_W-1:0];
            n_row = c_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (c_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores
    always_comb begin
        c_req.rd_en  = c_accept;
        c_req.col    = c_j;
        c_req.temp   = i_temp_in;
        c_req.wb_en  = r_v1 && c_en2;
        c_req.wb_col = r_m1.col;
    end

    hds_line_store u_line_store (
        .i_clk (i_clk),
        .i_req (c_req),
        .o_rd  (c_rd)
    );

    // stage 1: line store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (c_en1) begin
            r_v1 <= c_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_m1.temp   <= i_temp_in;
            r_m1.row    <= c_i;
            r_m1.col    <= c_j;
            r_m1.emit_a <= c_i != '0;
            r_m1.emit_b <= DIM_W'(c_i) == c_h - DIM_W'(1);
            r_m1.bnd    <= (c_i == ROW_W'(1)) || (c_j == '0) || c_last_col;
            r_m1.last   <= c_last_col;
        end
    end

    // stage 2: products
    assign c_sum = SUM_W'(c_rd.north) + SUM_W'(r_m1.temp)
                 + SUM_W'(c_rd.west) + SUM_W'(c_rd.east);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (c_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en2 && r_v1) begin
            r_m2     <= r_m1;
            r_c2     <= c_rd.centre;
            r_p_self <= PROD_W'(c_self) * PROD_W'(c_rd.centre);
            r_p_lam  <= PROD_W'(c_lam) * PROD_W'(c_sum);
        end
    end

    // stage 3: round, saturate, output register
    assign c_acc = ACC_W'(r_p_self) + ACC_W'(r_p_lam) + HALF_Q16;
    assign c_q   = c_acc[ACC_W-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_a <= 1'b0;
            r_pend_b <= 1'b0;
        end else if (c_en3) begin
            r_pend_a <= r_v2 && r_m2.emit_a;
            r_pend_b <= r_v2 && r_m2.emit_b;
        end else if (c_xfer) begin
            r_pend_a <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en3 && r_v2) begin
            r_val_a <= r_m2.bnd ? sat_q15(SUM_W'(r_c2)) : sat_q15(c_q);
            r_val_b <= sat_q15(SUM_W'(r_m2.temp));
            r_row3  <= r_m2.row;
            r_col3  <= r_m2.col;
            r_last3 <= r_m2.last;
        end
    end

    assign o_temp_out     = r_pend_a ? r_val_a : r_val_b;
    assign o_out_row      = r_pend_a ? IDX_W'(r_row3 - ROW_W'(1)) : IDX_W'(r_row3);
    assign o_out_col      = IDX_W'(r_col3);
    assign o_last_of_grid = !r_pend_a && r_last3;

    // checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && o_valid))
        else $error("input stalled with a free pipeline stage");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_grid) |-> (DIM_W'(o_out_col) == c_w - DIM_W'(1)))
        else $error("grid end flagged away from the last column");

    a_upper_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_a |-> (r_row3 != '0))
        else $error("stencil result pending for an arrival in the first row");

    a_second_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_a && r_pend_b && c_xfer) |=> (r_pend_b && !r_pend_a))
        else $error("boundary result of the last row dropped");

endmodule

### hdl/hds_line_store.sv
// Two line stores (previous row and the row before it) with registered reads.
// Depends on hds_pkg for widths and the request/read structs.
module hds_line_store import hds_pkg::*; (
    input  logic    i_clk,
    input  t_ls_req i_req,
    output t_ls_rd  o_rd
);

    logic [TEMP_W-1:0] r_above [MAX_WIDTH];
    logic [TEMP_W-1:0] r_two   [MAX_WIDTH];
    logic [TEMP_W-1:0] r_c;
    logic [TEMP_W-1:0] r_e;
    logic [TEMP_W-1:0] r_n;
    logic [TEMP_W-1:0] r_w;
    logic [COL_W-1:0]  c_col_e;

    assign c_col_e = i_req.col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_c <= r_above[i_req.col];
            r_e <= r_above[c_col_e];
            r_above[i_req.col] <= i_req.temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_n <= r_two[i_req.col];
        end
        if (i_req.wb_en) begin
            r_two[i_req.wb_col] <= r_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_w <= r_c;
        end
    end

    assign o_rd.centre = r_c;
    assign o_rd.east   = r_e;
    assign o_rd.north  = r_n;
    assign o_rd.west   = r_w;

endmodule
